[rtl/assert_macros.svh]
// ---------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms, clocked on clk_i and quiet in reset
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define SRE_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SRE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/sre_pkg.sv]
// ---------------------------------------------------------------------------
// sre_pkg
// shared constants, types and the symbol lookup of the radix digit emitter
// ---------------------------------------------------------------------------
package sre_pkg;

  localparam int MAX_SYMBOLS = 16;
  localparam int MAX_DIGITS  = 32;

  localparam int SYM_IDX_W   = 4;                          // symbol index into the table
  localparam int RADIX_W     = 5;
  localparam int DIG_IDX_W   = $clog2(MAX_DIGITS);
  localparam int DIG_CNT_W   = DIG_IDX_W + 1;
  localparam int VALUE_W     = 32;
  localparam int BIT_CNT_W   = $clog2(VALUE_W);
  localparam int CFG_W       = 64;
  localparam int ADDR_W      = 5;

  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;

  // register index, taken from paddr[4:3]
  localparam logic [1:0] REG_SYMBOLS_LOW  = 2'd0;
  localparam logic [1:0] REG_SYMBOLS_HIGH = 2'd1;
  localparam logic [1:0] REG_RADIX_COUNT  = 2'd2;

  typedef struct packed {
    logic [CFG_W-1:0]   sym_low;
    logic [CFG_W-1:0]   sym_high;
    logic [RADIX_W-1:0] radix;
  } cfg_t;

  typedef struct packed {
    logic load;        // capture value, clear counters
    logic chk_step;    // advance table check index
    logic div_step;    // one restoring division step
    logic push;        // store finished digit
    logic rd_issue;    // read top digit, pop
    logic emit_sign;   // show '-'
    logic emit_digit;  // show symbol of read digit
  } cmd_t;

  typedef struct packed {
    logic range_ok;    // radix count within 2..MAX_SYMBOLS
    logic chk_bad;     // current symbol is a sign or has a later duplicate
    logic chk_last;    // current symbol is the last in use
    logic neg;
    logic div_last;    // final step of this digit
    logic quot_zero;   // quotient after this step is zero
    logic stack_top;   // this push fills the stack
    logic count_zero;
  } sts_t;

  function automatic logic [7:0] sym_at(input logic [CFG_W-1:0] lo,
                                         input logic [CFG_W-1:0] hi,
                                         input logic [SYM_IDX_W-1:0] k);
    logic [2*CFG_W-1:0] both;
    both = {hi, lo};
    return both[k*8 +: 8];
  endfunction

endpackage

[rtl/signed_radix_digit_emitter.sv]
// ---------------------------------------------------------------------------
// signed_radix_digit_emitter
// signed 32-bit integer to text in a radix set by a table of digit symbols
// ---------------------------------------------------------------------------
// a run checks the table entry by entry, divides out each digit bit by bit onto the
//   stack, then pops and shows the digits; the first symbol ('-' or top digit) shows
//   once the table check or the last division is done
// one value at a time: start is taken only while idle; the pace is set by the shared
//   bit-serial divider
// a bad table ends the run in the check, with no output
// reset clears table, counters and sequencer, not the output payload or the stack;
// results are never held off
module signed_radix_digit_emitter (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // command channel
  input  logic                               start_i,
  output logic                               busy_o,
  input  logic signed [sre_pkg::VALUE_W-1:0] value_i,
  // result channel, one cycle per transaction
  output logic                               symbol_valid_o,
  output logic [7:0]                         symbol_o,
  output logic                               last_o,
  // register port
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [sre_pkg::ADDR_W-1:0]         paddr,
  input  logic [sre_pkg::CFG_W-1:0]          pwdata,
  output logic [sre_pkg::CFG_W-1:0]          prdata,
  output logic                               pready
);

  logic [sre_pkg::CFG_W-1:0]   symbols_low_q;
  logic [sre_pkg::CFG_W-1:0]   symbols_high_q;
  logic [sre_pkg::RADIX_W-1:0] radix_count_q;
  logic [1:0]                  reg_idx;
  logic                        wr_en;

  sre_pkg::cfg_t cfg;
  sre_pkg::cmd_t cmd;
  sre_pkg::sts_t sts;

  // registers are 64 bits, 8 bytes apart
  assign reg_idx = paddr[4:3];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      symbols_low_q  <= '0;
      symbols_high_q <= '0;
      radix_count_q  <= '0;
    end else if (wr_en) begin
      case (reg_idx)
        sre_pkg::REG_SYMBOLS_LOW:  symbols_low_q  <= pwdata;
        sre_pkg::REG_SYMBOLS_HIGH: symbols_high_q <= pwdata;
        sre_pkg::REG_RADIX_COUNT:  radix_count_q  <= pwdata[sre_pkg::RADIX_W-1:0];
        default: begin
          // unmapped, write dropped
        end
      endcase
    end
  end

  // read back
  always_comb begin
    case (reg_idx)
      sre_pkg::REG_SYMBOLS_LOW:  prdata = symbols_low_q;
      sre_pkg::REG_SYMBOLS_HIGH: prdata = symbols_high_q;
      sre_pkg::REG_RADIX_COUNT:  prdata = sre_pkg::CFG_W'(radix_count_q);
      default:                   prdata = '0;
    endcase
  end

  always_comb begin
    cfg.sym_low  = symbols_low_q;
    cfg.sym_high = symbols_high_q;
    cfg.radix    = radix_count_q;
  end

  // sequencer: check table, divide out digits onto the stack, pop and show
  sre_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .sts_i  (sts),
    .cmd_o  (cmd),
    .busy_o (busy_o)
  );

  // datapath: table check, divider, digit stack, output register
  sre_datapath u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .value_i       (value_i),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .symbol_valid_o(symbol_valid_o),
    .symbol_o      (symbol_o),
    .last_o        (last_o)
  );

endmodule

[rtl/sre_ram.sv]
// ---------------------------------------------------------------------------
// sre_ram
// generic single-write, single-read memory with registered read data
// ---------------------------------------------------------------------------
module sre_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/sre_datapath.sv]
// ---------------------------------------------------------------------------
// sre_datapath
// table check, bit-serial divider, digit stack and output register
// ---------------------------------------------------------------------------
module sre_datapath (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  sre_pkg::cfg_t                      cfg_i,
  input  logic signed [sre_pkg::VALUE_W-1:0] value_i,
  input  sre_pkg::cmd_t                      cmd_i,
  output sre_pkg::sts_t                      sts_o,
  output logic                               symbol_valid_o,
  output logic [7:0]                         symbol_o,
  output logic                               last_o
);

  logic [sre_pkg::VALUE_W-1:0]   quot_q, quot_d;
  logic [sre_pkg::SYM_IDX_W-1:0] rem_q, rem_d;
  logic [sre_pkg::BIT_CNT_W-1:0] bit_cnt_q;
  logic [sre_pkg::DIG_CNT_W-1:0] count_q;
  logic [sre_pkg::SYM_IDX_W-1:0] chk_idx_q;
  logic                          neg_q;
  logic                          strobe_q;
  logic [7:0]                    symbol_q;
  logic                          last_q;

  logic [sre_pkg::SYM_IDX_W:0]   trial;
  logic                          ge;
  logic [7:0]                    sym_cur;
  logic                          bad;
  logic [sre_pkg::SYM_IDX_W-1:0] rd_digit;
  logic [sre_pkg::DIG_IDX_W-1:0] rd_addr;

  // restoring division step
  always_comb begin
    trial  = {rem_q, quot_q[sre_pkg::VALUE_W-1]};
    ge     = (trial >= cfg_i.radix);
    rem_d  = ge ? sre_pkg::SYM_IDX_W'(trial - cfg_i.radix)
                : trial[sre_pkg::SYM_IDX_W-1:0];
    quot_d = {quot_q[sre_pkg::VALUE_W-2:0], ge};
  end

  // one table entry against the sign symbols and every later entry in use
  always_comb begin
    sym_cur = sre_pkg::sym_at(cfg_i.sym_low, cfg_i.sym_high, chk_idx_q);
    bad     = (sym_cur == sre_pkg::CH_MINUS) || (sym_cur == sre_pkg::CH_PLUS);
    for (int b = 0; b < sre_pkg::MAX_SYMBOLS; b++) begin
      if ((sre_pkg::RADIX_W'(b) > {1'b0, chk_idx_q}) &&
          (sre_pkg::RADIX_W'(b) < cfg_i.radix) &&
          (sre_pkg::sym_at(cfg_i.sym_low, cfg_i.sym_high,
                           sre_pkg::SYM_IDX_W'(b)) == sym_cur)) begin
        bad = 1'b1;
      end
    end
  end

  assign rd_addr = count_q[sre_pkg::DIG_IDX_W-1:0] - 1'b1;

  sre_ram #(
    .WIDTH(sre_pkg::SYM_IDX_W),
    .DEPTH(sre_pkg::MAX_DIGITS)
  ) u_stack (
    .clk_i   (clk_i),
    .we_i    (cmd_i.push),
    .waddr_i (count_q[sre_pkg::DIG_IDX_W-1:0]),
    .wdata_i (rem_d),
    .re_i    (cmd_i.rd_issue),
    .raddr_i (rd_addr),
    .rdata_o (rd_digit)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quot_q    <= '0;
      rem_q     <= '0;
      bit_cnt_q <= '0;
      count_q   <= '0;
      chk_idx_q <= '0;
      neg_q     <= 1'b0;
      strobe_q  <= 1'b0;
    end else begin
      strobe_q <= cmd_i.emit_sign | cmd_i.emit_digit;
      if (cmd_i.load) begin
        neg_q     <= value_i[sre_pkg::VALUE_W-1];
        quot_q    <= value_i[sre_pkg::VALUE_W-1] ? (~value_i + 1'b1) : value_i;
        rem_q     <= '0;
        bit_cnt_q <= '0;
        count_q   <= '0;
        chk_idx_q <= '0;
      end
      if (cmd_i.chk_step) begin
        chk_idx_q <= chk_idx_q + 1'b1;
      end
      if (cmd_i.div_step) begin
        quot_q    <= quot_d;
        bit_cnt_q <= bit_cnt_q + 1'b1;
        rem_q     <= cmd_i.push ? '0 : rem_d;
      end
      if (cmd_i.push) begin
        count_q <= count_q + 1'b1;
      end
      if (cmd_i.rd_issue) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_sign || cmd_i.emit_digit) begin
      symbol_q <= cmd_i.emit_sign ? sre_pkg::CH_MINUS
                                  : sre_pkg::sym_at(cfg_i.sym_low, cfg_i.sym_high, rd_digit);
      last_q   <= cmd_i.emit_digit && (count_q == '0);
    end
  end

  always_comb begin
    sts_o.range_ok   = (cfg_i.radix >= sre_pkg::RADIX_W'(2)) &&
                       (cfg_i.radix <= sre_pkg::RADIX_W'(sre_pkg::MAX_SYMBOLS));
    sts_o.chk_bad    = bad;
    sts_o.chk_last   = ({1'b0, chk_idx_q} == (cfg_i.radix - 1'b1));
    sts_o.neg        = neg_q;
    sts_o.div_last   = (bit_cnt_q == '1);
    sts_o.quot_zero  = (quot_d == '0);
    sts_o.stack_top  = (count_q == sre_pkg::DIG_CNT_W'(sre_pkg::MAX_DIGITS - 1));
    sts_o.count_zero = (count_q == '0);
  end

  assign symbol_valid_o = strobe_q;
  assign symbol_o       = symbol_q;
  assign last_o         = last_q;

endmodule

[rtl/sre_ctrl.sv]
// ---------------------------------------------------------------------------
// sre_ctrl
// sequencer: table check, digit division, stack readout
// ---------------------------------------------------------------------------
module sre_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  sre_pkg::sts_t sts_i,
  output sre_pkg::cmd_t cmd_o,
  output logic          busy_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_RD_ADDR,
    ST_RD_DATA
  } state_e;

  state_e state_q, state_d;
  logic   busy_q;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          if (sts_i.range_ok) begin
            state_d = ST_CHECK;
          end
        end
      end
      ST_CHECK: begin
        cmd_o.chk_step = 1'b1;
        if (sts_i.chk_bad) begin
          state_d = ST_IDLE;
        end else if (sts_i.chk_last) begin
          cmd_o.emit_sign = sts_i.neg;
          state_d         = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          cmd_o.push = 1'b1;
          if (sts_i.quot_zero || sts_i.stack_top) begin
            state_d = ST_RD_ADDR;
          end
        end
      end
      ST_RD_ADDR: begin
        cmd_o.rd_issue = 1'b1;
        state_d        = ST_RD_DATA;
      end
      ST_RD_DATA: begin
        cmd_o.emit_digit = 1'b1;
        state_d          = sts_i.count_zero ? ST_IDLE : ST_RD_ADDR;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      busy_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      busy_q  <= (state_d != ST_IDLE);
    end
  end

  assign busy_o = busy_q;

endmodule

[rtl/sre_checker.sv]
// ---------------------------------------------------------------------------
// sre_checker
// port-level checks of the radix digit emitter, bound to the top level
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module sre_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       start_i,
  input logic       busy_o,
  input logic       symbol_valid_o,
  input logic [7:0] symbol_o,
  input logic       last_o
);

  logic sign_shown;

  assign sign_shown = symbol_valid_o && (symbol_o == sre_pkg::CH_MINUS);

  // results only come out of a running conversion
  `SRE_ASSERT_IMPL(a_strobe_after_busy, symbol_valid_o, $past(busy_o), "result while idle")

  // nothing shows in the cycle after a command is taken
  `SRE_ASSERT_NEXT(a_no_strobe_on_start, start_i && !busy_o, !symbol_valid_o, "early result")

  // a run ends on its last symbol
  `SRE_ASSERT_NEXT(a_gap_after_last, symbol_valid_o && last_o, !symbol_valid_o, "after last")

  // the sign always has digits behind it
  `SRE_ASSERT_IMPL(a_sign_not_last, sign_shown, !last_o, "sign flagged last")

endmodule

bind signed_radix_digit_emitter sre_checker u_sre_checker (.*);
